### sv/wvpd_pkg.sv
// Package for the wheel velocity PD controller: sizes, state and register codes.
// Used by wheel_velocity_pd_controller; depends on nothing else.
package wvpd_pkg;

	localparam int WHEELS      = 4;
	localparam int COUNT_WIDTH = 32;
	localparam int WIDX_W      = (WHEELS > 1) ? $clog2(WHEELS) : 1;

	localparam int TGT_W   = 16;
	localparam int VEL_W   = 18;
	localparam int ERR_W   = 18;
	localparam int GAIN_W  = 12;
	localparam int SCALE_W = 16;
	localparam int MASK_W  = 4;
	localparam int DRV_W   = 17;
	localparam int DUTY_W  = 8;
	localparam int SLOTS   = 4;

	// serial multiplier: signed multiplicand times unsigned multiplier of up to SCALE_W bits
	localparam int PROD_W  = COUNT_WIDTH + SCALE_W + 1;
	localparam int MCNT_W  = $clog2(SCALE_W);
	localparam int PTERM_W = ERR_W + GAIN_W + 1 - 8;
	localparam int SUM_W   = PTERM_W + 3;

	localparam int VEL_LIMIT = 65536;
	localparam int ONE_Q15   = 32768;

	localparam int S_DATA_W   = ((2 * TGT_W + SLOTS * COUNT_WIDTH + 7) / 8) * 8;
	localparam int M_DATA_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic REQ_SET  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN    = 2'd0,
		REG_D_GAIN    = 2'd1,
		REG_VEL_SCALE = 2'd2,
		REG_DIR_MASK  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MUL_V,
		ST_ERR,
		ST_MUL_P,
		ST_DLOAD,
		ST_MUL_D,
		ST_SUM,
		ST_EMIT
	} state_t;

endpackage

### sv/wheel_velocity_pd_controller.sv
// Four-wheel PD velocity regulator with target feedforward, bit-serial datapath.
// Depends on wvpd_pkg.
//
// Usage:
//  - s_* stream: one word per request. tuser = request type (0 set targets,
//    1 control tick). A set-targets word updates the left/right targets and
//    produces nothing. A tick word produces one m_* word per wheel, FL, FR,
//    BL, BR, with tlast on the final wheel.
//  - cfg_* channel: register writes (0 p_gain, 1 d_gain, 2 velocity_scale,
//    3 forward_dir_mask); always ready, write only while the block is idle.
//  - Timing: a tick runs the wheels one after another through one shared
//    shift-add multiplier, one multiplier bit per cycle, first for the
//    velocity scale, then for P and D, with control steps between them.
//    A set-targets word is handled in the idle state.
//  - s_tready is high only while no tick is in flight.
//  - Output stall: each result sits in an output register; the sequencer
//    waits in its emit step while that register is still full.
//  - Reset clears targets, previous counts and errors, and restores the
//    register defaults (scale 256, direction mask 4'b1011).
module wheel_velocity_pd_controller
	import wvpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata, lsb up: left_target, right_target, front_left_count,
	// front_right_count, back_left_count, back_right_count
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  s_tuser,    // req_type
	// m_tdata, lsb up: duty[7:0], clockwise, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,
	output logic [1:0]            m_tuser,    // wheel
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [GAIN_W-1:0]  p_gain_q, d_gain_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MASK_W-1:0]  dir_mask_q;

	// controller state
	logic signed [TGT_W-1:0]       tgt_q      [2];
	logic        [COUNT_WIDTH-1:0] prev_cnt_q [WHEELS];
	logic signed [ERR_W-1:0]       prev_err_q [WHEELS];

	// sequencer and datapath
	state_t                    state_q, state_d;
	logic [WIDX_W-1:0]         wheel_q;
	logic [MCNT_W-1:0]         mcnt_q;
	logic [COUNT_WIDTH-1:0]    cnt_q [SLOTS];
	logic signed [PROD_W-1:0]  acc_q, mcand_q;
	logic [SCALE_W-1:0]        mplier_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [PTERM_W-1:0] pterm_q;
	logic signed [DRV_W-1:0]   drive_q;

	logic [WIDX_W+1:0]         wheel_ext;
	logic [1:0]                slot;
	logic                      last_wheel;
	logic                      out_free;
	logic                      in_acc;
	logic [COUNT_WIDTH-1:0]    delta;
	logic signed [PROD_W-1:0]  acc_shr;
	logic signed [PROD_W-1:0]  acc_step;
	logic signed [VEL_W-1:0]   vel;
	logic signed [TGT_W-1:0]   tgt_sel;
	logic signed [ERR_W-1:0]   err_new;
	logic signed [ERR_W:0]     derr;
	logic signed [SUM_W-1:0]   sum_w;
	logic signed [DRV_W-1:0]   drive_new;
	logic [DRV_W-1:0]          mag;
	logic [DRV_W+7:0]          duty_full;
	logic                      fwd_cw;

	localparam logic signed [PROD_W-1:0] VEL_HI = PROD_W'(VEL_LIMIT);
	localparam logic signed [PROD_W-1:0] VEL_LO = -PROD_W'(VEL_LIMIT);
	localparam logic signed [SUM_W-1:0]  DRV_HI = SUM_W'(ONE_Q15);
	localparam logic signed [SUM_W-1:0]  DRV_LO = -SUM_W'(ONE_Q15);

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;

	// wheel w uses count field, mask bit and label (w mod 4)
	assign wheel_ext  = {2'b00, wheel_q};
	assign slot       = wheel_ext[1:0];
	assign last_wheel = (wheel_q == WIDX_W'(WHEELS - 1));

	// datapath
	assign delta    = cnt_q[slot] - prev_cnt_q[wheel_q];
	assign acc_shr  = acc_q >>> 8;              // floor divide by 256
	assign acc_step = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign tgt_sel  = tgt_q[wheel_q[0]];        // even wheels left side

	always_comb begin
		if (acc_shr > VEL_HI) begin
			vel = VEL_W'(VEL_LIMIT);
		end else if (acc_shr < VEL_LO) begin
			vel = -VEL_W'(VEL_LIMIT);
		end else begin
			vel = acc_shr[VEL_W-1:0];
		end
	end

	assign err_new = ERR_W'(tgt_sel) - vel;
	assign derr    = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_err_q[wheel_q]);
	assign sum_w   = SUM_W'(tgt_sel) + SUM_W'(pterm_q) + $signed(acc_shr[SUM_W-1:0]);

	always_comb begin
		if (sum_w > DRV_HI) begin
			drive_new = DRV_W'(ONE_Q15);
		end else if (sum_w < DRV_LO) begin
			drive_new = -DRV_W'(ONE_Q15);
		end else begin
			drive_new = sum_w[DRV_W-1:0];
		end
	end

	// duty = |drive| * 255 >> 15, as (mag << 8) - mag
	assign mag       = drive_q[DRV_W-1] ? DRV_W'(-drive_q) : DRV_W'(drive_q);
	assign duty_full = {mag, 8'd0} - {8'd0, mag};
	assign fwd_cw    = dir_mask_q[slot];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == REQ_TICK) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_MUL_V;
			ST_MUL_V: begin
				if (mcnt_q == '0) state_d = ST_ERR;
			end
			ST_ERR:   state_d = ST_MUL_P;
			ST_MUL_P: begin
				if (mcnt_q == '0) state_d = ST_DLOAD;
			end
			ST_DLOAD: state_d = ST_MUL_D;
			ST_MUL_D: begin
				if (mcnt_q == '0) state_d = ST_SUM;
			end
			ST_SUM:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = last_wheel ? ST_IDLE : ST_DELTA;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q   <= '0;
			d_gain_q   <= '0;
			scale_q    <= SCALE_W'(256);
			dir_mask_q <= MASK_W'(11);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_P_GAIN:    p_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_D_GAIN:    d_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_VEL_SCALE: scale_q    <= cfg_data[SCALE_W-1:0];
				REG_DIR_MASK:  dir_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q  <= '0;
			m_tvalid <= 1'b0;
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
			for (int i = 0; i < WHEELS; i++) begin
				prev_cnt_q[i] <= '0;
				prev_err_q[i] <= '0;
			end
		end else begin
			// the emit step reloads the output word itself
			if (state_q != ST_EMIT && m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wheel_q <= '0;
						if (s_tuser == REQ_SET) begin
							tgt_q[0] <= s_tdata[TGT_W-1:0];
							tgt_q[1] <= s_tdata[2*TGT_W-1:TGT_W];
						end
					end
				end
				ST_DELTA: prev_cnt_q[wheel_q] <= cnt_q[slot];
				ST_DLOAD: prev_err_q[wheel_q] <= err_q;
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						wheel_q  <= wheel_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int i = 0; i < SLOTS; i++) begin
						cnt_q[i] <= s_tdata[2*TGT_W + i*COUNT_WIDTH +: COUNT_WIDTH];
					end
				end
			end
			ST_DELTA: begin
				acc_q    <= '0;
				mcand_q  <= PROD_W'($signed(delta));
				mplier_q <= scale_q;
				mcnt_q   <= MCNT_W'(SCALE_W - 1);
			end
			ST_MUL_V, ST_MUL_P, ST_MUL_D: begin
				acc_q    <= acc_step;
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				mcnt_q   <= mcnt_q - 1'b1;
			end
			ST_ERR: begin
				err_q    <= err_new;
				acc_q    <= '0;
				mcand_q  <= PROD_W'(err_new);
				mplier_q <= SCALE_W'(p_gain_q);
				mcnt_q   <= MCNT_W'(GAIN_W - 1);
			end
			ST_DLOAD: begin
				pterm_q  <= acc_shr[PTERM_W-1:0];
				acc_q    <= '0;
				mcand_q  <= PROD_W'(derr);
				mplier_q <= SCALE_W'(d_gain_q);
				mcnt_q   <= MCNT_W'(GAIN_W - 1);
			end
			ST_SUM: drive_q <= drive_new;
			ST_EMIT: begin
				if (out_free) begin
					m_tdata <= {{(M_DATA_W-DUTY_W-1){1'b0}},
						(drive_q > 0) ? fwd_cw : ~fwd_cw,
						duty_full[15 +: DUTY_W]};
					m_tuser <= slot;
					m_tlast <= last_wheel;
				end
			end
			default: ;
		endcase
	end

endmodule
